>>> hdl/md5_stream_hasher_defines.svh
// Assertion macros shared by the MD5 stream hasher modules.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MD5_STREAM_HASHER_DEFINES_SVH
`define MD5_STREAM_HASHER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MD5SH_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define MD5SH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/md5sh_pkg.sv
// Types, constants and table functions of the MD5 stream hasher.
// Used by md5sh_core and md5_stream_hasher; depends on nothing.
package md5sh_pkg;

    typedef logic [31:0]      md5sh_word_t;
    typedef logic [3:0][31:0] md5sh_quad_t;

    // Input request: kind plus message byte
    typedef struct packed {
        logic       kind;
        logic [7:0] message_byte;
    } md5sh_in_t;

    // Result request: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5sh_out_t;

    // Status of the round unit toward the sequencer
    typedef struct packed {
        logic       busy;
        logic       done;
        logic [3:0] msg_index;
    } md5sh_core_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_EMIT
    } md5sh_state_t;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Chaining words after reset, index 0 = A
    localparam md5sh_quad_t INIT_VECTOR = {32'h10325476, 32'h98badcfe,
                                           32'hefcdab89, 32'h67452301};

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] POS_LEN_PRE = 6'd55;
    localparam logic [5:0] POS_LAST    = 6'd63;
    localparam logic [5:0] ROUND_LAST  = 6'd63;
    localparam logic [1:0] WORD_LAST   = 2'd3;

    // Sine-derived additive constant of each round
    function automatic logic [31:0] md5sh_sine(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate amount: index is {round group, round low two bits}
    function automatic logic [4:0] md5sh_rot(input logic [3:0] idx);
        logic [4:0] s;
        case (idx)
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // Rotate left by n, 0 < n < 32
    function automatic logic [31:0] md5sh_rotl(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {v, v} << n;
        return dbl[63:32];
    endfunction

endpackage

>>> hdl/md5sh_core.sv
// MD5 round unit: one round per cycle through 64 rounds on four working words.
// Depends on md5sh_pkg and md5_stream_hasher_defines.svh.
`include "md5_stream_hasher_defines.svh"

module md5sh_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  md5sh_pkg::md5sh_quad_t      chain_in,
    input  md5sh_pkg::md5sh_word_t      msg_word,
    output md5sh_pkg::md5sh_quad_t      work_out,
    output md5sh_pkg::md5sh_core_stat_t stat
);

    md5sh_pkg::md5sh_quad_t work_reg;
    logic [5:0]             round_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [31:0] fa, fb, fc, fd;
    logic [31:0] f_val;
    logic [31:0] t_val;
    logic [31:0] b_new;
    logic [3:0]  ri;
    logic [3:0]  g_idx;

    // Round function and message schedule
    always_comb begin
        fa = work_reg[0];
        fb = work_reg[1];
        fc = work_reg[2];
        fd = work_reg[3];
        ri = round_reg[3:0];
        case (round_reg[5:4])
            2'd0: begin
                f_val = (fb & fc) | (~fb & fd);
                g_idx = ri;
            end
            2'd1: begin
                f_val = (fb & fd) | (fc & ~fd);
                g_idx = ri * 4'd5 + 4'd1;
            end
            2'd2: begin
                f_val = fb ^ fc ^ fd;
                g_idx = ri * 4'd3 + 4'd5;
            end
            2'd3: begin
                f_val = fc ^ (fb | ~fd);
                g_idx = ri * 4'd7;
            end
            default: begin
                f_val = 32'h0;
                g_idx = 4'd0;
            end
        endcase
        t_val = fa + f_val + md5sh_pkg::md5sh_sine(round_reg) + msg_word;
        b_new = fb + md5sh_pkg::md5sh_rotl(t_val,
                    md5sh_pkg::md5sh_rot({round_reg[5:4], round_reg[1:0]}));
    end

    // Sequence the rounds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                round_reg <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == md5sh_pkg::ROUND_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load from the chain, then shift the working words each round
    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= chain_in;
        end else if (busy_reg) begin
            work_reg[0] <= fd;
            work_reg[1] <= b_new;
            work_reg[2] <= fb;
            work_reg[3] <= fc;
        end
    end

    assign work_out       = work_reg;
    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.msg_index = g_idx;

    `MD5SH_ASSERT_SAME(a_start_idle, aclk, aresetn, start, !busy_reg, "start while busy")
    `MD5SH_ASSERT_NEXT(a_round_step, aclk, aresetn,
        busy_reg && !start && round_reg != md5sh_pkg::ROUND_LAST,
        busy_reg && round_reg == $past(round_reg) + 6'd1, "round counter skipped")
    `MD5SH_ASSERT_NEXT(a_done_after_last, aclk, aresetn,
        busy_reg && !start && round_reg == md5sh_pkg::ROUND_LAST,
        done_reg && !busy_reg, "no done after last round")

endmodule

>>> hdl/md5_stream_hasher.sv
// MD5 stream hasher top level: byte packing, padding sequencer, chain and digest output.
// Depends on md5sh_pkg, md5sh_core and md5_stream_hasher_defines.svh.
//
// Message bytes are taken one per cycle while idle. The byte that completes a 64-byte
// block starts the round unit, which runs one MD5 round per cycle: the block is then
// not ready until the 64 rounds are run and added into the chaining words.
// An end request writes the padding and length one byte per cycle: 64 minus the
// current byte position when that position is 55 or less, otherwise 128 minus it
// (at most 72 bytes), with a compression after each filled block (one or two), then
// presents the digest as four words, A first, one per cycle while m_ready is high.
// After the last word the block returns to the initial vector and is ready for the
// next message.
`include "md5_stream_hasher_defines.svh"

module md5_stream_hasher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  md5sh_pkg::md5sh_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output md5sh_pkg::md5sh_out_t m_data
);

    md5sh_pkg::md5sh_state_t state_reg, state_next;
    logic [5:0]              pos_reg, pos_next;
    logic [63:0]             bit_len_reg, bit_len_next;
    logic                    pad_first_reg, pad_first_next;
    logic                    len_phase_reg, len_phase_next;
    logic                    pad_mode_reg, pad_mode_next;
    logic                    final_reg, final_next;
    logic [1:0]              emit_idx_reg, emit_idx_next;
    md5sh_pkg::md5sh_quad_t  chain_reg, chain_next;

    logic [31:0] block_reg [16];

    logic                        wr_en;
    logic [7:0]                  wr_byte;
    logic                        core_start;
    md5sh_pkg::md5sh_quad_t      work;
    md5sh_pkg::md5sh_core_stat_t core_stat;
    logic [31:0]                 msg_word;

    assign msg_word = block_reg[core_stat.msg_index];

    md5sh_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (core_start),
        .chain_in (chain_reg),
        .msg_word (msg_word),
        .work_out (work),
        .stat     (core_stat)
    );

    // Sequencer: next state and outputs
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        bit_len_next   = bit_len_reg;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        pad_mode_next  = pad_mode_reg;
        final_next     = final_reg;
        emit_idx_next  = emit_idx_reg;
        chain_next     = chain_reg;
        wr_en          = 1'b0;
        wr_byte        = s_data.message_byte;
        core_start     = 1'b0;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        case (state_reg)
            md5sh_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.kind == md5sh_pkg::KIND_BYTE) begin
                        wr_en        = 1'b1;
                        pos_next     = pos_reg + 6'd1;
                        bit_len_next = bit_len_reg + 64'd8;
                        if (pos_reg == md5sh_pkg::POS_LAST) begin
                            core_start = 1'b1;
                            final_next = 1'b0;
                            state_next = md5sh_pkg::ST_COMP;
                        end
                    end else begin
                        pad_mode_next  = 1'b1;
                        pad_first_next = 1'b1;
                        len_phase_next = 1'b0;
                        state_next     = md5sh_pkg::ST_PAD;
                    end
                end
            end
            md5sh_pkg::ST_PAD: begin
                // Write marker, zeros or length byte at the current position
                wr_en = 1'b1;
                if (pad_first_reg) begin
                    wr_byte = md5sh_pkg::PAD_MARK;
                end else if (len_phase_reg) begin
                    wr_byte = bit_len_reg[{pos_reg[2:0], 3'b000} +: 8];
                end else begin
                    wr_byte = 8'h00;
                end
                pad_first_next = 1'b0;
                pos_next       = pos_reg + 6'd1;
                if (pos_reg == md5sh_pkg::POS_LEN_PRE) begin
                    len_phase_next = 1'b1;
                end
                if (pos_reg == md5sh_pkg::POS_LAST) begin
                    core_start = 1'b1;
                    final_next = len_phase_reg;
                    state_next = md5sh_pkg::ST_COMP;
                end
            end
            md5sh_pkg::ST_COMP: begin
                // Fold the working words into the chain when rounds finish
                if (core_stat.done) begin
                    for (int i = 0; i < 4; i++) begin
                        chain_next[i] = chain_reg[i] + work[i];
                    end
                    if (final_reg) begin
                        emit_idx_next = 2'd0;
                        state_next    = md5sh_pkg::ST_EMIT;
                    end else if (pad_mode_reg) begin
                        state_next = md5sh_pkg::ST_PAD;
                    end else begin
                        state_next = md5sh_pkg::ST_IDLE;
                    end
                end
            end
            md5sh_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    emit_idx_next = emit_idx_reg + 2'd1;
                    if (emit_idx_reg == md5sh_pkg::WORD_LAST) begin
                        // Return to the initial vector
                        chain_next     = md5sh_pkg::INIT_VECTOR;
                        pos_next       = '0;
                        bit_len_next   = '0;
                        pad_first_next = 1'b0;
                        len_phase_next = 1'b0;
                        pad_mode_next  = 1'b0;
                        final_next     = 1'b0;
                        state_next     = md5sh_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = md5sh_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control and chain state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= md5sh_pkg::ST_IDLE;
            pos_reg       <= '0;
            bit_len_reg   <= '0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            pad_mode_reg  <= 1'b0;
            final_reg     <= 1'b0;
            emit_idx_reg  <= '0;
            chain_reg     <= md5sh_pkg::INIT_VECTOR;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bit_len_reg   <= bit_len_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
            pad_mode_reg  <= pad_mode_next;
            final_reg     <= final_next;
            emit_idx_reg  <= emit_idx_next;
            chain_reg     <= chain_next;
        end
    end

    // Pack bytes little-endian into the block words
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            block_reg[pos_reg[5:2]][{pos_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

    assign m_data.digest_word = chain_reg[emit_idx_reg];
    assign m_data.word_index  = emit_idx_reg;
    assign m_data.last_word   = (emit_idx_reg == md5sh_pkg::WORD_LAST);

    `MD5SH_ASSERT_SAME(a_no_overlap, aclk, aresetn, s_ready, !m_valid,
        "ready while digest pending")
    `MD5SH_ASSERT_NEXT(a_ready_after_digest, aclk, aresetn,
        m_valid && m_ready && m_data.last_word, s_ready, "not ready after digest")
    `MD5SH_ASSERT_SAME(a_core_in_comp, aclk, aresetn,
        core_stat.busy || core_stat.done, state_reg == md5sh_pkg::ST_COMP,
        "round unit active outside compression")

endmodule

>>> tb/sv/md5_stream_hasher_tb.sv
// Testbench for md5_stream_hasher: feeds byte and end requests, predicts the digest.
// Depends on md5sh_pkg and the md5_stream_hasher RTL; nothing else.
// A directed table runs first, then random messages under random idling on both sides.
module md5_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT = 600000;
    localparam int         NUM_ROWS    = 18;
    localparam int         MIN_ITEMS   = 180;
    localparam int         MIN_ENDS    = 12;
    localparam int         DRAIN_WAIT  = 300;
    localparam logic [5:0] LEN_POS     = 6'd56;

    // Digests of well-known messages, word A in the low lane
    localparam md5sh_pkg::md5sh_quad_t EMPTY_DIG =
        {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4};
    localparam md5sh_pkg::md5sh_quad_t A_DIG =
        {32'h61267769, 32'he299c331, 32'ha8b6f1c0, 32'hb975c10c};
    localparam md5sh_pkg::md5sh_quad_t ABC_DIG =
        {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190};

    // Additive round constants and rotate amounts of the compression
    localparam logic [0:63][31:0] ROUND_K = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam logic [0:15][4:0] ROT_AMT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    // One row of the directed table: request plus an optional typed-in digest
    typedef struct packed {
        md5sh_pkg::md5sh_in_t   req;
        logic                   typed;
        md5sh_pkg::md5sh_quad_t want;
    } stim_row_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    md5sh_pkg::md5sh_in_t  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    md5sh_pkg::md5sh_out_t m_data;

    // Predictor state
    md5sh_pkg::md5sh_quad_t chain_st;
    logic [31:0]            blk_words [16];
    logic [5:0]             fill_pos;
    logic [63:0]            msg_bits;

    md5sh_pkg::md5sh_out_t digest_q [$];
    stim_row_t             stim_rows [NUM_ROWS];

    int       cycle_cnt  = 0;
    int       err_cnt    = 0;
    int       items_sent = 0;
    int       ends_sent  = 0;
    int       burst_left = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;

    md5_stream_hasher i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock: 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Count cycles and stop a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        if (err_cnt < 50) begin
            $display("tb: mismatch at cycle %0d: %s", cycle_cnt, msg);
        end
        err_cnt++;
    endtask

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void clear_chain();
        chain_st = md5sh_pkg::INIT_VECTOR;
        fill_pos = '0;
        msg_bits = '0;
    endfunction

    // Run the 64 rounds over the current block and fold into the chain
    function automatic void compress_block_words();
        logic [31:0] a, b, c, d, f, t, nb;
        int          g;
        a = chain_st[0];
        b = chain_st[1];
        c = chain_st[2];
        d = chain_st[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            t  = a + f + ROUND_K[r] + blk_words[g];
            nb = b + rol32(t, ROT_AMT[(r / 16) * 4 + r % 4]);
            a  = d;
            d  = c;
            c  = b;
            b  = nb;
        end
        chain_st[0] = chain_st[0] + a;
        chain_st[1] = chain_st[1] + b;
        chain_st[2] = chain_st[2] + c;
        chain_st[3] = chain_st[3] + d;
    endfunction

    // Place one byte little-endian in the block; compress when it fills
    function automatic void absorb_byte(input logic [7:0] b);
        blk_words[fill_pos[5:2]][8 * fill_pos[1:0] +: 8] = b;
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == '0) begin
            compress_block_words();
        end
    endfunction

    // Fold one request into the digest state; return 1 with the digest on end
    function automatic logic fold_request(input md5sh_pkg::md5sh_in_t req,
                                          output md5sh_pkg::md5sh_quad_t dig);
        logic [63:0] len;
        dig = '0;
        if (req.kind == md5sh_pkg::KIND_BYTE) begin
            absorb_byte(req.message_byte);
            msg_bits = msg_bits + 64'd8;
            return 1'b0;
        end
        len = msg_bits;
        absorb_byte(md5sh_pkg::PAD_MARK);
        while (fill_pos != LEN_POS) begin
            absorb_byte(8'h00);
        end
        for (int i = 0; i < 8; i++) begin
            absorb_byte(len[8 * i +: 8]);
        end
        dig = chain_st;
        clear_chain();
        return 1'b1;
    endfunction

    // Drive one request in bursts with random gaps; predict on acceptance
    task automatic push_request(input md5sh_pkg::md5sh_in_t req, input logic typed,
                                input md5sh_pkg::md5sh_quad_t typed_dig);
        md5sh_pkg::md5sh_quad_t dig;
        md5sh_pkg::md5sh_out_t  res;
        int                     gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid = 1'b1;
        s_data  = req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        items_sent++;
        burst_left--;
        if (fold_request(req, dig)) begin
            if (typed) begin
                dig = typed_dig;
            end
            for (int i = 0; i < 4; i++) begin
                res.digest_word = dig[i];
                res.word_index  = 2'(i);
                res.last_word   = (2'(i) == md5sh_pkg::WORD_LAST);
                digest_q.push_back(res);
            end
            ends_sent++;
        end
        @(negedge aclk);
    endtask

    // Receiver: stall on one of four patterns, picked anew at random
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:     m_ready = 1'b1;
            RX_COIN:     m_ready = 1'($urandom_range(0, 1));
            RX_SPARSE:   m_ready = ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_ready = (cycle_cnt % 5 != 0);
            default:     m_ready = 1'b1;
        endcase
    end

    // Check each accepted digest word against the oldest expectation
    always @(posedge aclk) begin
        md5sh_pkg::md5sh_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                flag_mismatch("digest word with nothing expected");
            end else begin
                want = digest_q.pop_front();
                if (m_data.digest_word !== want.digest_word) begin
                    flag_mismatch($sformatf("digest_word %h, expected %h",
                                            m_data.digest_word, want.digest_word));
                end
                if (m_data.word_index !== want.word_index) begin
                    flag_mismatch($sformatf("word_index %0d, expected %0d",
                                            m_data.word_index, want.word_index));
                end
                if (m_data.last_word !== want.last_word) begin
                    flag_mismatch($sformatf("last_word %b, expected %b",
                                            m_data.last_word, want.last_word));
                end
            end
        end
    end

    // Stimulus: reset, directed table, random messages, drain
    initial begin
        int                     pad_lens [8];
        int                     len;
        int                     pick;
        md5sh_pkg::md5sh_in_t   req;
        md5sh_pkg::md5sh_quad_t none;
        pad_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        none = '0;
        clear_chain();
        stim_rows = '{
            {md5sh_pkg::KIND_END,  8'h00, 1'b1, EMPTY_DIG},
            {md5sh_pkg::KIND_BYTE, 8'h61, 1'b0, 128'h0},
            {md5sh_pkg::KIND_END,  8'h00, 1'b1, A_DIG},
            {md5sh_pkg::KIND_BYTE, 8'h61, 1'b0, 128'h0},
            {md5sh_pkg::KIND_BYTE, 8'h62, 1'b0, 128'h0},
            {md5sh_pkg::KIND_BYTE, 8'h63, 1'b0, 128'h0},
            {md5sh_pkg::KIND_END,  8'h00, 1'b1, ABC_DIG},
            // end request byte is ignored: still the empty message
            {md5sh_pkg::KIND_END,  8'hff, 1'b1, EMPTY_DIG},
            {md5sh_pkg::KIND_BYTE, 8'h00, 1'b0, 128'h0},
            {md5sh_pkg::KIND_BYTE, 8'hff, 1'b0, 128'h0},
            {md5sh_pkg::KIND_BYTE, 8'h80, 1'b0, 128'h0},
            {md5sh_pkg::KIND_BYTE, 8'h55, 1'b0, 128'h0},
            {md5sh_pkg::KIND_BYTE, 8'haa, 1'b0, 128'h0},
            {md5sh_pkg::KIND_END,  8'h5a, 1'b0, 128'h0},
            {md5sh_pkg::KIND_BYTE, 8'hff, 1'b0, 128'h0},
            {md5sh_pkg::KIND_END,  8'h00, 1'b0, 128'h0},
            {md5sh_pkg::KIND_BYTE, 8'h00, 1'b0, 128'h0},
            {md5sh_pkg::KIND_END,  8'hff, 1'b0, 128'h0}
        };

        // Hold reset, then release it on a falling clock edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (stim_rows[i]) begin
            push_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
        end

        // Random messages: half short, some longer, some on padding boundaries, some noise
        while (items_sent < MIN_ITEMS || ends_sent < MIN_ENDS) begin
            pick = $urandom_range(0, 9);
            if (pick == 9) begin
                repeat ($urandom_range(1, 8)) begin
                    req.kind         = $urandom_range(0, 1) ? md5sh_pkg::KIND_END
                                                            : md5sh_pkg::KIND_BYTE;
                    req.message_byte = 8'($urandom_range(0, 255));
                    push_request(req, 1'b0, none);
                end
            end else begin
                if (pick < 5) begin
                    len = $urandom_range(0, 12);
                end else if (pick == 5) begin
                    len = pad_lens[$urandom_range(0, 7)];
                end else begin
                    len = $urandom_range(13, 70);
                end
                repeat (len) begin
                    req.kind         = md5sh_pkg::KIND_BYTE;
                    req.message_byte = 8'($urandom_range(0, 255));
                    push_request(req, 1'b0, none);
                end
                req.kind         = md5sh_pkg::KIND_END;
                req.message_byte = 8'($urandom_range(0, 255));
                push_request(req, 1'b0, none);
            end
        end

        // Close any open message so nothing is left half-hashed
        req.kind         = md5sh_pkg::KIND_END;
        req.message_byte = 8'h00;
        push_request(req, 1'b0, none);
        s_valid = 1'b0;

        // Drain outstanding digests, then watch for stray output
        while (digest_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/md5sh_pkg.sv
hdl/md5sh_core.sv
hdl/md5_stream_hasher.sv
tb/sv/md5_stream_hasher_tb.sv
